@@ src/descriptor_chain_allocator_assert.svh @@
// ============================================================================
// Descriptor chain allocator assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ============================================================================
`ifndef DESCRIPTOR_CHAIN_ALLOCATOR_ASSERT_SVH
`define DESCRIPTOR_CHAIN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication
`define DCA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DCA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/dca_pkg.sv @@
// ============================================================================
// Descriptor chain allocator package
// Shared constants, status codes, control types and the free-slot search.
// ============================================================================
package dca_pkg;

    // Pool sizing; descriptor indices travel in 8-bit fields
    localparam int POOL_DEPTH = 256;
    localparam int IDX_W      = 8;
    localparam int INDEX_SPAN = 1 << IDX_W;
    localparam int USABLE     = (POOL_DEPTH < INDEX_SPAN) ? POOL_DEPTH : INDEX_SPAN;
    localparam int SLOT_W     = $clog2(USABLE);

    // Status field
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_OK          = 2'd0;
    localparam logic [ST_W-1:0] ST_SHORT       = 2'd1;
    localparam logic [ST_W-1:0] ST_DOUBLE_FREE = 2'd2;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result item packing: status, first, second, third, zero padding
    localparam int OUT_FIELDS_W = ST_W + 3 * IDX_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND0,
        S_FIND1,
        S_FIND2,
        S_LINK0,
        S_LINK1,
        S_F_READ,
        S_F_STEP,
        S_RESP
    } t_dca_state;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_FIND0,
        OP_FIND1,
        OP_FIND2,
        OP_LINK0,
        OP_LINK1,
        OP_READ,
        OP_STEP
    } t_dca_op;

    typedef struct packed {
        t_dca_op          op;
        logic             load_in;
        logic             resp_load;
        logic             resp_slots;
        logic [ST_W-1:0]  resp_status;
    } t_dca_cmd;

    typedef struct packed {
        logic hit;
        logic cur_bad;
        logic cur_more;
        logic out_free;
    } t_dca_stat;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } t_find;

    // Lowest set bit of the free map
    function automatic t_find find_first(input logic [USABLE-1:0] v);
        t_find r;
        r.hit = 1'b0;
        r.idx = '0;
        for (int i = USABLE - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.hit = 1'b1;
                r.idx = SLOT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ src/descriptor_chain_allocator.sv @@
// ============================================================================
// Descriptor chain allocator
// Free-list allocator for a pool of 256 ring descriptors.
// ============================================================================
// Input channel s_axis: tuser carries the kind (allocate a three-descriptor
// chain, or free the chain starting at the head index in tdata). Output
// channel m_axis returns exactly one result item per request: status and the
// three allocated descriptor numbers (zero unless an allocate succeeded).
// Allocate runs three find-lowest-free passes over the free map, one per
// cycle, then two link-memory writes and the result load. A failed
// allocate skips the remaining passes and the link writes.
// Free-chain walks the link memory, a registered read and then a release
// for each descriptor; a free or out-of-pool descriptor ends the walk at
// its read step with a double-free status.
// One request is in flight at a time; s_axis_tready is high while idle,
// also while a finished result waits in the output register, so the next
// item can be taken in the cycle after the result is loaded.
// Reset (synchronous, active low) marks every descriptor free with no links
// and empties the output register; no clearing pass is needed.
// If m_axis_tready stays low the result is held and the block stops before
// loading its next result.
// ============================================================================
module descriptor_chain_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,  // [7:0] head_index
    input  logic [0:0]                s_axis_tuser,  // [0] kind
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [1:0] status, [9:2] first_slot, [17:10] second_slot,
    // [25:18] third_slot, [31:26] zero
    output logic [dca_pkg::OUT_W-1:0] m_axis_tdata
);

    dca_pkg::t_dca_cmd  w_cmd;
    dca_pkg::t_dca_stat w_stat;

    // Controller
    dca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath
    dca_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

@@ src/dca_ctrl.sv @@
// ============================================================================
// Descriptor chain allocator controller
// Sequences allocate searches, link writes and free-chain walks.
// ============================================================================
module dca_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_kind,
    output logic               o_in_ready,
    input  dca_pkg::t_dca_stat i_stat,
    output dca_pkg::t_dca_cmd  o_cmd
);

    dca_pkg::t_dca_state r_state, n_state;
    logic [dca_pkg::ST_W-1:0] r_st, n_st;
    logic                     r_show, n_show;

    // State and pending result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dca_pkg::S_IDLE;
            r_st    <= dca_pkg::ST_OK;
            r_show  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            r_show  <= n_show;
        end
    end

    // Next state and commands
    always_comb begin
        n_state           = r_state;
        n_st              = r_st;
        n_show            = r_show;
        o_in_ready        = 1'b0;
        o_cmd.op          = dca_pkg::OP_NONE;
        o_cmd.load_in     = 1'b0;
        o_cmd.resp_load   = 1'b0;
        o_cmd.resp_slots  = r_show;
        o_cmd.resp_status = r_st;
        unique case (r_state)
            dca_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_show        = 1'b0;
                    n_state       = (i_in_kind == dca_pkg::KIND_FREE) ?
                                    dca_pkg::S_F_READ : dca_pkg::S_FIND0;
                end
            end
            dca_pkg::S_FIND0: begin
                o_cmd.op = dca_pkg::OP_FIND0;
                if (i_stat.hit) begin
                    n_state = dca_pkg::S_FIND1;
                end else begin
                    n_st    = dca_pkg::ST_SHORT;
                    n_state = dca_pkg::S_RESP;
                end
            end
            dca_pkg::S_FIND1: begin
                o_cmd.op = dca_pkg::OP_FIND1;
                if (i_stat.hit) begin
                    n_state = dca_pkg::S_FIND2;
                end else begin
                    n_st    = dca_pkg::ST_SHORT;
                    n_state = dca_pkg::S_RESP;
                end
            end
            dca_pkg::S_FIND2: begin
                o_cmd.op = dca_pkg::OP_FIND2;
                if (i_stat.hit) begin
                    n_state = dca_pkg::S_LINK0;
                end else begin
                    n_st    = dca_pkg::ST_SHORT;
                    n_state = dca_pkg::S_RESP;
                end
            end
            dca_pkg::S_LINK0: begin
                o_cmd.op = dca_pkg::OP_LINK0;
                n_state  = dca_pkg::S_LINK1;
            end
            dca_pkg::S_LINK1: begin
                o_cmd.op = dca_pkg::OP_LINK1;
                n_st     = dca_pkg::ST_OK;
                n_show   = 1'b1;
                n_state  = dca_pkg::S_RESP;
            end
            // Check the current descriptor and fetch its link
            dca_pkg::S_F_READ: begin
                o_cmd.op = dca_pkg::OP_READ;
                if (i_stat.cur_bad) begin
                    n_st    = dca_pkg::ST_DOUBLE_FREE;
                    n_state = dca_pkg::S_RESP;
                end else begin
                    n_state = dca_pkg::S_F_STEP;
                end
            end
            // Release it and follow the link if there is one
            dca_pkg::S_F_STEP: begin
                o_cmd.op = dca_pkg::OP_STEP;
                if (i_stat.cur_more) begin
                    n_state = dca_pkg::S_F_READ;
                end else begin
                    n_st    = dca_pkg::ST_OK;
                    n_state = dca_pkg::S_RESP;
                end
            end
            dca_pkg::S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.resp_load = 1'b1;
                    n_state         = dca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dca_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ src/dca_dpath.sv @@
// ============================================================================
// Descriptor chain allocator datapath
// Free map, has-next marks, link memory, slot registers and result register.
// ============================================================================
module dca_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [dca_pkg::IDX_W-1:0]  i_head,
    input  dca_pkg::t_dca_cmd          i_cmd,
    output dca_pkg::t_dca_stat         o_stat,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [dca_pkg::OUT_W-1:0]  o_out_data
);

    logic [dca_pkg::USABLE-1:0] r_free;
    logic [dca_pkg::USABLE-1:0] r_lvalid;
    logic [dca_pkg::IDX_W-1:0]  r_link [dca_pkg::USABLE];
    logic [dca_pkg::IDX_W-1:0]  r_rdata;
    logic [dca_pkg::IDX_W-1:0]  r_cur;
    logic [dca_pkg::SLOT_W-1:0] r_slot0, r_slot1, r_slot2;
    logic                       r_out_valid;
    logic [dca_pkg::OUT_W-1:0]  r_out_data;

    logic [dca_pkg::USABLE-1:0] w_mask;
    dca_pkg::t_find             w_find;
    logic [dca_pkg::SLOT_W-1:0] w_ci;
    logic                       w_in_pool;
    logic [dca_pkg::IDX_W-1:0]  w_first, w_second, w_third;
    logic                       w_wr_en;
    logic [dca_pkg::SLOT_W-1:0] w_wr_addr;
    logic [dca_pkg::IDX_W-1:0]  w_wr_data;

    // Search the free map with slots already picked masked out
    always_comb begin
        w_mask = '0;
        if (i_cmd.op == dca_pkg::OP_FIND1 || i_cmd.op == dca_pkg::OP_FIND2) begin
            w_mask[r_slot0] = 1'b1;
        end
        if (i_cmd.op == dca_pkg::OP_FIND2) begin
            w_mask[r_slot1] = 1'b1;
        end
    end

    assign w_find = dca_pkg::find_first(r_free & ~w_mask);

    // Current walk position
    assign w_ci      = r_cur[dca_pkg::SLOT_W-1:0];
    assign w_in_pool = ({1'b0, r_cur} < (dca_pkg::IDX_W + 1)'(dca_pkg::USABLE));

    assign o_stat.hit      = w_find.hit;
    assign o_stat.cur_bad  = !w_in_pool || r_free[w_ci];
    assign o_stat.cur_more = r_lvalid[w_ci];
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Walk pointer and picked slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cur <= i_head;
        end else if (i_cmd.op == dca_pkg::OP_STEP) begin
            r_cur <= r_rdata;
        end
        if (i_cmd.op == dca_pkg::OP_FIND0) begin
            r_slot0 <= w_find.idx;
        end
        if (i_cmd.op == dca_pkg::OP_FIND1) begin
            r_slot1 <= w_find.idx;
        end
        if (i_cmd.op == dca_pkg::OP_FIND2) begin
            r_slot2 <= w_find.idx;
        end
    end

    // Free map and has-next marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free   <= '1;
            r_lvalid <= '0;
        end else if (i_cmd.op == dca_pkg::OP_LINK0) begin
            r_free[r_slot0]   <= 1'b0;
            r_free[r_slot1]   <= 1'b0;
            r_free[r_slot2]   <= 1'b0;
            r_lvalid[r_slot0] <= 1'b1;
            r_lvalid[r_slot1] <= 1'b1;
            r_lvalid[r_slot2] <= 1'b0;
        end else if (i_cmd.op == dca_pkg::OP_STEP) begin
            r_free[w_ci]   <= 1'b1;
            r_lvalid[w_ci] <= 1'b0;
        end
    end

    // Link memory: one write port, one registered read port
    assign w_wr_en   = (i_cmd.op == dca_pkg::OP_LINK0) || (i_cmd.op == dca_pkg::OP_LINK1);
    assign w_wr_addr = (i_cmd.op == dca_pkg::OP_LINK0) ? r_slot0 : r_slot1;
    assign w_wr_data = (i_cmd.op == dca_pkg::OP_LINK0) ?
                       dca_pkg::IDX_W'(r_slot1) : dca_pkg::IDX_W'(r_slot2);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_link[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.op == dca_pkg::OP_READ) begin
            r_rdata <= r_link[w_ci];
        end
    end

    // Result register
    assign w_first  = i_cmd.resp_slots ? dca_pkg::IDX_W'(r_slot0) : '0;
    assign w_second = i_cmd.resp_slots ? dca_pkg::IDX_W'(r_slot1) : '0;
    assign w_third  = i_cmd.resp_slots ? dca_pkg::IDX_W'(r_slot2) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.resp_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp_load) begin
            r_out_data <= {{(dca_pkg::OUT_W - dca_pkg::OUT_FIELDS_W){1'b0}},
                           w_third, w_second, w_first, i_cmd.resp_status};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ src/dca_checker.sv @@
// ============================================================================
// Descriptor chain allocator checker
// Port-level checks on result items and request accepts, bound to the top level.
// ============================================================================
`include "descriptor_chain_allocator_assert.svh"

module dca_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [dca_pkg::OUT_W-1:0] m_axis_tdata
);

    // Stalled result stays put
    `DCA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result item changed")

    // Status is one of the defined codes
    `DCA_ASSERT_IMP(a_status_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[1:0] == dca_pkg::ST_OK || m_axis_tdata[1:0] == dca_pkg::ST_SHORT || m_axis_tdata[1:0] == dca_pkg::ST_DOUBLE_FREE, "undefined status code")

    // A failed item reports no descriptors
    `DCA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1:0] != dca_pkg::ST_OK, m_axis_tdata[25:2] == 24'd0, "failed item carries slots")

    // An allocated chain is in ascending descriptor order
    `DCA_ASSERT_IMP(a_chain_order, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1:0] == dca_pkg::ST_OK && m_axis_tdata[17:10] != 8'd0, m_axis_tdata[9:2] < m_axis_tdata[17:10] && m_axis_tdata[17:10] < m_axis_tdata[25:18], "allocated chain out of order")

    // Only one request in flight: no accept in the cycle after an accept
    `DCA_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item accepted while busy")

endmodule

bind descriptor_chain_allocator dca_checker u_dca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ bench/descriptor_chain_allocator_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Descriptor chain allocator testbench
// Drives allocate and free-chain requests, with directed corner cases first
// and then random fill and drain runs. A local copy of the descriptor pool
// predicts every result item, and the monitor checks each one in order.
// ============================================================================
module descriptor_chain_allocator_tb;

    localparam int CHAIN_LEN      = 3;
    localparam int PHASE_ITEMS    = 645;
    localparam int RUN_ITEMS      = 129;
    localparam int QUEUE_AHEAD    = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic                      kind;
        logic [dca_pkg::IDX_W-1:0] head;
    } t_req;

    typedef struct packed {
        logic [dca_pkg::ST_W-1:0]  status;
        logic [dca_pkg::IDX_W-1:0] first;
        logic [dca_pkg::IDX_W-1:0] second;
        logic [dca_pkg::IDX_W-1:0] third;
    } t_chain_res;

    // Block ports
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata  = '0;  // [7:0] head_index
    logic [0:0]                s_axis_tuser  = '0;  // [0] kind
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // [1:0] status, [9:2] first_slot, [17:10] second_slot,
    // [25:18] third_slot, [31:26] zero
    logic [dca_pkg::OUT_W-1:0] m_axis_tdata;

    // Local copy of the pool
    bit                        desc_free   [dca_pkg::USABLE];
    logic [dca_pkg::IDX_W-1:0] desc_next   [dca_pkg::USABLE];
    bit                        desc_linked [dca_pkg::USABLE];

    t_req       request_q[$];
    t_chain_res chain_expect_q[$];
    t_chain_res live_chains[$];

    int send_idle_pct  = 11;
    int recv_idle_pct  = 54;
    int mismatch_count = 0;
    int result_count   = 0;
    int quiet_cycles   = 0;

    descriptor_chain_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Applies one request to the local pool and returns its result item
    function automatic t_chain_res predict_chain(input logic kind,
                                                 input logic [dca_pkg::IDX_W-1:0] head);
        t_chain_res                r;
        int                        got [CHAIN_LEN];
        int                        n;
        int                        cur;
        bit                        walking;
        bit                        more;
        logic [dca_pkg::IDX_W-1:0] nxt;
        r = '0;
        if (kind == dca_pkg::KIND_ALLOC) begin
            // three lowest free descriptors, linked in ascending order
            n = 0;
            for (int s = 0; s < dca_pkg::USABLE && n < CHAIN_LEN; s++) begin
                if (desc_free[s]) begin
                    got[n] = s;
                    n++;
                end
            end
            if (n < CHAIN_LEN) begin
                r.status = dca_pkg::ST_SHORT;
            end else begin
                for (int k = 0; k < CHAIN_LEN; k++) begin
                    desc_free[got[k]] = 1'b0;
                    if (k + 1 < CHAIN_LEN) begin
                        desc_next[got[k]]   = dca_pkg::IDX_W'(got[k + 1]);
                        desc_linked[got[k]] = 1'b1;
                    end else begin
                        desc_next[got[k]]   = '0;
                        desc_linked[got[k]] = 1'b0;
                    end
                end
                r.status = dca_pkg::ST_OK;
                r.first  = dca_pkg::IDX_W'(got[0]);
                r.second = dca_pkg::IDX_W'(got[1]);
                r.third  = dca_pkg::IDX_W'(got[2]);
            end
        end else begin
            // walk from the head; a free or out-of-pool descriptor stops it
            r.status = dca_pkg::ST_DOUBLE_FREE;
            cur      = head;
            walking  = 1'b1;
            for (int steps = 0; steps <= dca_pkg::USABLE && walking; steps++) begin
                if (cur >= dca_pkg::USABLE || desc_free[cur]) begin
                    walking = 1'b0;
                end else begin
                    more             = desc_linked[cur];
                    nxt              = desc_next[cur];
                    desc_free[cur]   = 1'b1;
                    desc_next[cur]   = '0;
                    desc_linked[cur] = 1'b0;
                    if (!more) begin
                        r.status = dca_pkg::ST_OK;
                        walking  = 1'b0;
                    end
                    cur = nxt;
                end
            end
        end
        return r;
    endfunction

    task automatic queue_req(input logic kind, input logic [dca_pkg::IDX_W-1:0] head);
        t_req q;
        q.kind = kind;
        q.head = head;
        request_q.push_back(q);
    endtask

    // Sender stays quiet until every result has come back
    task automatic wait_drained();
        while (request_q.size() != 0 || s_axis_tvalid || chain_expect_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Driver: request side and result-side ready
    always @(posedge i_clk) begin : driver
        t_req nxt_req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt_req          = request_q.pop_front();
                    s_axis_tvalid   <= 1'b1;
                    s_axis_tdata    <= nxt_req.head;
                    s_axis_tuser[0] <= nxt_req.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on request accept, check on result accept
    always @(posedge i_clk) begin : monitor
        t_chain_res                want;
        t_chain_res                seen;
        logic [dca_pkg::OUT_W-1:0] want_word;
        if (!i_rst_n) begin
            for (int s = 0; s < dca_pkg::USABLE; s++) begin
                desc_free[s]   = 1'b1;
                desc_next[s]   = '0;
                desc_linked[s] = 1'b0;
            end
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = predict_chain(s_axis_tuser[0], s_axis_tdata);
                chain_expect_q.push_back(want);
                if (s_axis_tuser[0] == dca_pkg::KIND_ALLOC && want.status == dca_pkg::ST_OK)
                    live_chains.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen.status = m_axis_tdata[1:0];
                seen.first  = m_axis_tdata[9:2];
                seen.second = m_axis_tdata[17:10];
                seen.third  = m_axis_tdata[25:18];
                if (chain_expect_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result %0d unexpected: status %0d slots %0d %0d %0d",
                                 result_count, seen.status, seen.first, seen.second,
                                 seen.third);
                end else begin
                    want      = chain_expect_q.pop_front();
                    want_word = '0;
                    want_word[25:0] = {want.third, want.second, want.first, want.status};
                    if (m_axis_tdata !== want_word) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("result %0d: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d pad %0h",
                                     result_count, want.status, want.first, want.second,
                                     want.third, seen.status, seen.first, seen.second,
                                     seen.third, m_axis_tdata[dca_pkg::OUT_W-1:26]);
                    end
                end
                result_count++;
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus
    initial begin : stimulus
        t_chain_res                c;
        logic [dca_pkg::IDX_W-1:0] head;
        int                        sel;
        int                        pos;
        bit                        filling;

        // directed: chain building, partial frees, double frees, cross-chain walk
        queue_req(dca_pkg::KIND_ALLOC, 8'h00);   // 0,1,2
        queue_req(dca_pkg::KIND_ALLOC, 8'h00);   // 3,4,5
        queue_req(dca_pkg::KIND_FREE,  8'd1);    // middle of a chain: frees 1,2
        queue_req(dca_pkg::KIND_FREE,  8'd2);    // head already free
        queue_req(dca_pkg::KIND_FREE,  8'd0);    // frees 0, then meets free 1 mid-walk
        queue_req(dca_pkg::KIND_ALLOC, 8'hFF);   // head ignored: 0,1,2 again
        queue_req(dca_pkg::KIND_FREE,  8'hFF);   // top index, free
        queue_req(dca_pkg::KIND_FREE,  8'd3);    // whole chain 3,4,5
        queue_req(dca_pkg::KIND_ALLOC, 8'hA5);   // 3,4,5
        queue_req(dca_pkg::KIND_FREE,  8'd5);    // tail only; 4 keeps its stale link
        queue_req(dca_pkg::KIND_ALLOC, 8'h5A);   // 5,6,7
        queue_req(dca_pkg::KIND_FREE,  8'd3);    // walks 3,4 into the chain 5,6,7
        queue_req(dca_pkg::KIND_FREE,  8'd0);    // 0,1,2
        queue_req(dca_pkg::KIND_FREE,  8'd0);    // now free
        queue_req(dca_pkg::KIND_ALLOC, 8'h00);   // 0,1,2

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // random: alternating fill and drain runs under three idling patterns
        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            unique case (phase)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                while (request_q.size() >= QUEUE_AHEAD) @(negedge i_clk);
                filling = ((i / RUN_ITEMS) % 2) == 0;
                head    = dca_pkg::IDX_W'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < (filling ? 85 : 25)) begin
                    queue_req(dca_pkg::KIND_ALLOC, head);
                end else begin
                    // mostly real chains, from the head or part way in
                    if (live_chains.size() != 0 && $urandom_range(0, 9) != 0) begin
                        sel = $urandom_range(0, live_chains.size() - 1);
                        c   = live_chains[sel];
                        live_chains.delete(sel);
                        pos = $urandom_range(0, 99);
                        if (pos < 70)
                            head = c.first;
                        else if (pos < 85)
                            head = c.second;
                        else
                            head = c.third;
                    end
                    queue_req(dca_pkg::KIND_FREE, head);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && chain_expect_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
